// ----- rtl/ezk_pkg.sv -----
// Shared types, constants and arithmetic helpers for the z-y-x Euler joint kinematics block.
// No dependencies; every other file in rtl imports this package.
`timescale 1ns / 1ps
package ezk_pkg;

    localparam int TRIG_ITERATIONS_DEF = 16;
    localparam int ATAN_ENTRIES        = 24;
    localparam int RESULTS             = 8;
    localparam int MERGE_LAT           = 3;

    localparam int ANG_W  = 16;
    localparam int RATE_W = 16;
    localparam int Z_W    = 29;
    localparam int TRIG_W = 27;
    localparam int VAL_W  = 32;

    localparam logic signed [Z_W-1:0] ANG_PI       = 29'sd52707179;
    localparam logic signed [Z_W-1:0] ANG_HALF_PI  = 29'sd26353589;
    localparam logic signed [Z_W-1:0] ANG_TWO_PI   = 29'sd105414357;
    localparam logic signed [TRIG_W-1:0] CORDIC_START = 27'sd10188014;

    localparam logic [1:0] KIND_ROT  = 2'd0;
    localparam logic [1:0] KIND_SUB  = 2'd1;
    localparam logic [1:0] KIND_VEL  = 2'd2;
    localparam logic [1:0] KIND_BIAS = 2'd3;

    typedef struct packed {
        logic signed [TRIG_W-1:0] sin;
        logic signed [TRIG_W-1:0] cos;
    } t_trig;

    typedef struct packed {
        logic signed [VAL_W-1:0] a;
        logic signed [VAL_W-1:0] b;
        logic signed [VAL_W-1:0] c;
    } t_vec;

    function automatic logic signed [Z_W-1:0] atan_q24(input int idx);
        logic signed [Z_W-1:0] v;
        case (idx)
            0:  v = 29'sd13176795;
            1:  v = 29'sd7778716;
            2:  v = 29'sd4110060;
            3:  v = 29'sd2086331;
            4:  v = 29'sd1047214;
            5:  v = 29'sd524117;
            6:  v = 29'sd262123;
            7:  v = 29'sd131069;
            8:  v = 29'sd65536;
            9:  v = 29'sd32768;
            10: v = 29'sd16384;
            11: v = 29'sd8192;
            12: v = 29'sd4096;
            13: v = 29'sd2048;
            14: v = 29'sd1024;
            15: v = 29'sd512;
            16: v = 29'sd256;
            17: v = 29'sd128;
            18: v = 29'sd64;
            19: v = 29'sd32;
            20: v = 29'sd16;
            21: v = 29'sd8;
            22: v = 29'sd4;
            23: v = 29'sd2;
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic logic signed [TRIG_W-1:0] mul24(input logic signed [TRIG_W-1:0] a,
                                                       input logic signed [TRIG_W-1:0] b);
        logic signed [2*TRIG_W-1:0] p;
        logic signed [2*TRIG_W-1:0] r;
        p = (2*TRIG_W)'(a) * (2*TRIG_W)'(b);
        r = (p + ((2*TRIG_W)'(1) <<< 23)) >>> 24;
        return r[TRIG_W-1:0];
    endfunction

    function automatic logic signed [VAL_W-1:0] rnd_sat(input logic signed [63:0] v,
                                                        input int unsigned s);
        logic signed [63:0] t;
        t = (v + (64'sd1 <<< (s - 1))) >>> s;
        if (t > 64'sd2147483647) begin
            t = 64'sd2147483647;
        end else if (t < -64'sd2147483648) begin
            t = -64'sd2147483648;
        end
        return t[VAL_W-1:0];
    endfunction

    function automatic logic [1:0] kind_of(input logic [2:0] idx);
        logic [1:0] k;
        case (idx)
            3'd0, 3'd1, 3'd2: k = KIND_ROT;
            3'd3, 3'd4, 3'd5: k = KIND_SUB;
            3'd6:             k = KIND_VEL;
            default:          k = KIND_BIAS;
        endcase
        return k;
    endfunction

    function automatic logic [1:0] row_of(input logic [2:0] idx);
        logic [1:0] r;
        case (idx)
            3'd0, 3'd3: r = 2'd0;
            3'd1, 3'd4: r = 2'd1;
            3'd2, 3'd5: r = 2'd2;
            default:    r = 2'd0;
        endcase
        return r;
    endfunction

endpackage

// ----- rtl/ezk_cordic_lane.sv -----
// One pipelined CORDIC lane: quadrant reduction, then one register stage per iteration.
// Depends on ezk_pkg for the angle constants, arctangent table and trig struct.
`timescale 1ns / 1ps
module ezk_cordic_lane #(
    parameter int TRIG_ITERATIONS = ezk_pkg::TRIG_ITERATIONS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_en,
    input  logic signed [ezk_pkg::ANG_W-1:0]    i_angle,
    output ezk_pkg::t_trig                      o_trig
);
    import ezk_pkg::*;

    localparam int N = (TRIG_ITERATIONS > ATAN_ENTRIES) ? ATAN_ENTRIES : TRIG_ITERATIONS;

    logic signed [TRIG_W-1:0] r_x [N+1];
    logic signed [TRIG_W-1:0] r_y [N+1];
    logic signed [Z_W-1:0]    r_z [N+1];
    logic                     r_flip [N+1];

    logic signed [Z_W-1:0] w_z0;
    logic signed [Z_W-1:0] w_z1;
    logic signed [Z_W-1:0] w_z2;
    logic                  w_flip;

    always_comb begin
        w_z0 = {{(Z_W-ANG_W-12){i_angle[ANG_W-1]}}, i_angle, 12'b0};
        if (w_z0 > ANG_PI) begin
            w_z1 = w_z0 - ANG_TWO_PI;
        end else if (w_z0 < -ANG_PI) begin
            w_z1 = w_z0 + ANG_TWO_PI;
        end else begin
            w_z1 = w_z0;
        end
        if (w_z1 > ANG_HALF_PI) begin
            w_z2   = w_z1 - ANG_PI;
            w_flip = 1'b1;
        end else if (w_z1 < -ANG_HALF_PI) begin
            w_z2   = w_z1 + ANG_PI;
            w_flip = 1'b1;
        end else begin
            w_z2   = w_z1;
            w_flip = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0]    <= CORDIC_START;
            r_y[0]    <= '0;
            r_z[0]    <= w_z2;
            r_flip[0] <= w_flip;
        end
    end

    for (genvar i = 0; i < N; i++) begin : g_iter
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_flip[i+1] <= r_flip[i];
                if (!r_z[i][Z_W-1]) begin
                    r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] - atan_q24(i);
                end else begin
                    r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] + atan_q24(i);
                end
            end
        end
    end

    assign o_trig.cos = r_flip[N] ? -r_x[N] : r_x[N];
    assign o_trig.sin = r_flip[N] ? -r_y[N] : r_y[N];

endmodule

// ----- rtl/ezk_merge.sv -----
// Merging pipeline: combines the three lanes' sine and cosine with the rates into eight results.
// Three register stages (trig products, second products, sums with rounding and saturation).
// Depends on ezk_pkg.
`timescale 1ns / 1ps
module ezk_merge (
    input  logic                                i_clk,
    input  logic                                i_en,
    input  ezk_pkg::t_trig                      i_trig_x,
    input  ezk_pkg::t_trig                      i_trig_y,
    input  ezk_pkg::t_trig                      i_trig_z,
    input  logic signed [ezk_pkg::RATE_W-1:0]   i_rate_x,
    input  logic signed [ezk_pkg::RATE_W-1:0]   i_rate_y,
    input  logic signed [ezk_pkg::RATE_W-1:0]   i_rate_z,
    output ezk_pkg::t_vec                       o_res [ezk_pkg::RESULTS]
);
    import ezk_pkg::*;

    localparam int QQ_W = 2 * RATE_W;
    localparam int VP_W = TRIG_W + RATE_W;
    localparam int BP_W = TRIG_W + QQ_W;

    logic signed [TRIG_W-1:0] r1_s0, r1_c0, r1_s1, r1_c1, r1_s2, r1_c2;
    logic signed [TRIG_W-1:0] r1_c0c1, r1_s0c1, r1_c0s1, r1_s0s1;
    logic signed [TRIG_W-1:0] r1_c1s2, r1_c1c2, r1_s1s2, r1_s1c2;
    logic signed [RATE_W-1:0] r1_qx, r1_qy, r1_qz;
    logic signed [QQ_W-1:0]   r1_qxy, r1_qxz, r1_qyz;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_s0   <= i_trig_x.sin;
            r1_c0   <= i_trig_x.cos;
            r1_s1   <= i_trig_y.sin;
            r1_c1   <= i_trig_y.cos;
            r1_s2   <= i_trig_z.sin;
            r1_c2   <= i_trig_z.cos;
            r1_c0c1 <= mul24(i_trig_x.cos, i_trig_y.cos);
            r1_s0c1 <= mul24(i_trig_x.sin, i_trig_y.cos);
            r1_c0s1 <= mul24(i_trig_x.cos, i_trig_y.sin);
            r1_s0s1 <= mul24(i_trig_x.sin, i_trig_y.sin);
            r1_c1s2 <= mul24(i_trig_y.cos, i_trig_z.sin);
            r1_c1c2 <= mul24(i_trig_y.cos, i_trig_z.cos);
            r1_s1s2 <= mul24(i_trig_y.sin, i_trig_z.sin);
            r1_s1c2 <= mul24(i_trig_y.sin, i_trig_z.cos);
            r1_qx   <= i_rate_x;
            r1_qy   <= i_rate_y;
            r1_qz   <= i_rate_z;
            r1_qxy  <= QQ_W'(i_rate_x) * QQ_W'(i_rate_y);
            r1_qxz  <= QQ_W'(i_rate_x) * QQ_W'(i_rate_z);
            r1_qyz  <= QQ_W'(i_rate_y) * QQ_W'(i_rate_z);
        end
    end

    logic signed [TRIG_W-1:0] r2_p0, r2_p1, r2_p2, r2_p3, r2_p4, r2_p5, r2_p6, r2_p7;
    logic signed [TRIG_W-1:0] r2_c0c1, r2_s0c1, r2_s1, r2_c1s2, r2_c1c2, r2_c2, r2_s2;
    logic signed [RATE_W-1:0] r2_qz;
    logic signed [VP_W-1:0]   r2_v0, r2_v1, r2_v2, r2_v3, r2_v4;
    logic signed [BP_W-1:0]   r2_b0, r2_b1, r2_b2, r2_b3, r2_b4, r2_b5, r2_b6;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_p0   <= mul24(r1_c0s1, r1_s2);
            r2_p1   <= mul24(r1_s0, r1_c2);
            r2_p2   <= mul24(r1_s0s1, r1_s2);
            r2_p3   <= mul24(r1_c0, r1_c2);
            r2_p4   <= mul24(r1_c0s1, r1_c2);
            r2_p5   <= mul24(r1_s0, r1_s2);
            r2_p6   <= mul24(r1_s0s1, r1_c2);
            r2_p7   <= mul24(r1_c0, r1_s2);
            r2_c0c1 <= r1_c0c1;
            r2_s0c1 <= r1_s0c1;
            r2_s1   <= r1_s1;
            r2_c1s2 <= r1_c1s2;
            r2_c1c2 <= r1_c1c2;
            r2_c2   <= r1_c2;
            r2_s2   <= r1_s2;
            r2_qz   <= r1_qz;
            r2_v0   <= VP_W'(r1_s1) * VP_W'(r1_qx);
            r2_v1   <= VP_W'(r1_c1s2) * VP_W'(r1_qx);
            r2_v2   <= VP_W'(r1_c2) * VP_W'(r1_qy);
            r2_v3   <= VP_W'(r1_c1c2) * VP_W'(r1_qx);
            r2_v4   <= VP_W'(r1_s2) * VP_W'(r1_qy);
            r2_b0   <= BP_W'(r1_c1) * BP_W'(r1_qxy);
            r2_b1   <= BP_W'(r1_s1s2) * BP_W'(r1_qxy);
            r2_b2   <= BP_W'(r1_c1c2) * BP_W'(r1_qxz);
            r2_b3   <= BP_W'(r1_s2) * BP_W'(r1_qyz);
            r2_b4   <= BP_W'(r1_s1c2) * BP_W'(r1_qxy);
            r2_b5   <= BP_W'(r1_c1s2) * BP_W'(r1_qxz);
            r2_b6   <= BP_W'(r1_c2) * BP_W'(r1_qyz);
        end
    end

    t_vec r3_res [RESULTS];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_res[0].a <= rnd_sat(64'(r2_c0c1), 8);
            r3_res[0].b <= rnd_sat(64'(r2_s0c1), 8);
            r3_res[0].c <= rnd_sat(-64'(r2_s1), 8);
            r3_res[1].a <= rnd_sat(64'(r2_p0) - 64'(r2_p1), 8);
            r3_res[1].b <= rnd_sat(64'(r2_p2) + 64'(r2_p3), 8);
            r3_res[1].c <= rnd_sat(64'(r2_c1s2), 8);
            r3_res[2].a <= rnd_sat(64'(r2_p4) + 64'(r2_p5), 8);
            r3_res[2].b <= rnd_sat(64'(r2_p6) - 64'(r2_p7), 8);
            r3_res[2].c <= rnd_sat(64'(r2_c1c2), 8);
            r3_res[3].a <= rnd_sat(-64'(r2_s1), 8);
            r3_res[3].b <= '0;
            r3_res[3].c <= 32'sd65536;
            r3_res[4].a <= rnd_sat(64'(r2_c1s2), 8);
            r3_res[4].b <= rnd_sat(64'(r2_c2), 8);
            r3_res[4].c <= '0;
            r3_res[5].a <= rnd_sat(64'(r2_c1c2), 8);
            r3_res[5].b <= rnd_sat(-64'(r2_s2), 8);
            r3_res[5].c <= '0;
            r3_res[6].a <= rnd_sat((64'(r2_qz) <<< 24) - 64'(r2_v0), 16);
            r3_res[6].b <= rnd_sat(64'(r2_v1) + 64'(r2_v2), 16);
            r3_res[6].c <= rnd_sat(64'(r2_v3) - 64'(r2_v4), 16);
            r3_res[7].a <= rnd_sat(-64'(r2_b0), 24);
            r3_res[7].b <= rnd_sat(64'(r2_b2) - 64'(r2_b1) - 64'(r2_b3), 24);
            r3_res[7].c <= rnd_sat(-64'(r2_b4) - 64'(r2_b5) - 64'(r2_b6), 24);
        end
    end

    assign o_res = r3_res;

endmodule

// ----- rtl/euler_zyx_joint_kinematics.sv -----
// Top level of the z-y-x Euler joint kinematics block: three CORDIC lanes, merge pipeline,
// and the result buffer that sends eight transfers per item. Depends on ezk_pkg,
// ezk_cordic_lane and ezk_merge.
//
// Each accepted item runs through three parallel CORDIC lanes (one register stage for quadrant
// reduction plus one per iteration, capped at 24 iterations) and a three-stage product and
// rounding pipeline. The eight results are then sent one per cycle, while i_stall is low, from
// an eight-entry buffer; that single result port limits the sustained item rate. Up to
// TRIG_ITERATIONS + 4 further items are taken into the pipeline while a buffer drains.
// Outputs are saturated Q15.16; the block holds no state between items.
`timescale 1ns / 1ps
module euler_zyx_joint_kinematics #(
    parameter int TRIG_ITERATIONS = ezk_pkg::TRIG_ITERATIONS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic signed [ezk_pkg::ANG_W-1:0]    i_angle_x,
    input  logic signed [ezk_pkg::ANG_W-1:0]    i_angle_y,
    input  logic signed [ezk_pkg::ANG_W-1:0]    i_angle_z,
    input  logic signed [ezk_pkg::RATE_W-1:0]   i_rate_x,
    input  logic signed [ezk_pkg::RATE_W-1:0]   i_rate_y,
    input  logic signed [ezk_pkg::RATE_W-1:0]   i_rate_z,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [1:0]                          o_kind,
    output logic [1:0]                          o_row,
    output logic signed [ezk_pkg::VAL_W-1:0]    o_value_a,
    output logic signed [ezk_pkg::VAL_W-1:0]    o_value_b,
    output logic signed [ezk_pkg::VAL_W-1:0]    o_value_c,
    output logic                                o_last
);
    import ezk_pkg::*;

    localparam int N        = (TRIG_ITERATIONS > ATAN_ENTRIES) ? ATAN_ENTRIES : TRIG_ITERATIONS;
    localparam int LANE_LAT = N + 1;
    localparam int DEPTH    = LANE_LAT + MERGE_LAT;
    localparam logic [2:0] LAST_IDX = 3'(RESULTS - 1);

    logic [DEPTH-1:0]         r_vld;
    logic signed [RATE_W-1:0] r_rate_x [LANE_LAT];
    logic signed [RATE_W-1:0] r_rate_y [LANE_LAT];
    logic signed [RATE_W-1:0] r_rate_z [LANE_LAT];
    logic                     r_busy;
    logic [2:0]               r_cnt;
    t_vec                     r_buf [RESULTS];

    logic   w_free;
    logic   w_en;
    logic   w_load;
    t_trig  w_trig_x;
    t_trig  w_trig_y;
    t_trig  w_trig_z;
    t_vec   w_res [RESULTS];

    assign w_free  = !r_busy || ((r_cnt == LAST_IDX) && !i_stall);
    assign w_en    = !r_vld[DEPTH-1] || w_free;
    assign w_load  = r_vld[DEPTH-1] && w_free;
    assign o_stall = !w_en;

    ezk_cordic_lane #(.TRIG_ITERATIONS(TRIG_ITERATIONS)) u_lane_x (
        .i_clk(i_clk), .i_en(w_en), .i_angle(i_angle_x), .o_trig(w_trig_x)
    );
    ezk_cordic_lane #(.TRIG_ITERATIONS(TRIG_ITERATIONS)) u_lane_y (
        .i_clk(i_clk), .i_en(w_en), .i_angle(i_angle_y), .o_trig(w_trig_y)
    );
    ezk_cordic_lane #(.TRIG_ITERATIONS(TRIG_ITERATIONS)) u_lane_z (
        .i_clk(i_clk), .i_en(w_en), .i_angle(i_angle_z), .o_trig(w_trig_z)
    );

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_rate_x[0] <= i_rate_x;
            r_rate_y[0] <= i_rate_y;
            r_rate_z[0] <= i_rate_z;
            for (int k = 1; k < LANE_LAT; k++) begin
                r_rate_x[k] <= r_rate_x[k-1];
                r_rate_y[k] <= r_rate_y[k-1];
                r_rate_z[k] <= r_rate_z[k-1];
            end
        end
    end

    ezk_merge u_merge (
        .i_clk(i_clk),
        .i_en(w_en),
        .i_trig_x(w_trig_x),
        .i_trig_y(w_trig_y),
        .i_trig_z(w_trig_z),
        .i_rate_x(r_rate_x[LANE_LAT-1]),
        .i_rate_y(r_rate_y[LANE_LAT-1]),
        .i_rate_z(r_rate_z[LANE_LAT-1]),
        .o_res(w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            if (w_en) begin
                r_vld <= {r_vld[DEPTH-2:0], i_valid};
            end
            if (w_load) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy && !i_stall) begin
                if (r_cnt == LAST_IDX) begin
                    r_busy <= 1'b0;
                end else begin
                    r_cnt <= r_cnt + 3'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_buf <= w_res;
        end
    end

    assign o_valid   = r_busy;
    assign o_kind    = kind_of(r_cnt);
    assign o_row     = row_of(r_cnt);
    assign o_value_a = r_buf[r_cnt].a;
    assign o_value_b = r_buf[r_cnt].b;
    assign o_value_c = r_buf[r_cnt].c;
    assign o_last    = (r_cnt == LAST_IDX);

`ifndef NO_ASSERTIONS
    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_vld[DEPTH-1] && r_busy))
        else $error("input stalled while the pipeline can advance");

    a_next_item_starts_at_row0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && o_last) |=> (!o_valid || (o_kind == KIND_ROT && o_row == 2'd0)))
        else $error("new item did not start with rotation row 0");

    a_subspace_row0_const: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_kind == KIND_SUB && o_row == 2'd0) |-> (o_value_c == 32'sd65536))
        else $error("subspace row 0 third element wrong");
`endif

endmodule
